>>> rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and function for the range frame checker
// Status codes, register indexes, frame constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int RANGE_W   = 16;

    localparam logic [7:0] HEADER_CHAR = 8'h54;     // 'T'
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [2:0] FRAME_LEN   = 3'd4;
    localparam logic [2:0] COUNT_MAX   = 3'd7;

    localparam logic [RANGE_W-1:0] MIN_MM_RESET = 16'd500;
    localparam logic [RANGE_W-1:0] MAX_MM_RESET = 16'd40000;
    localparam logic [RANGE_W-1:0] RAW_ALL_ONES = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_CLOSE    = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_INVALID      = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_BAD_HEADER   = 3'd5,
        ST_CRC_MISMATCH = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_MM = 2'd0,
        REG_MAX_MM = 2'd1
    } cfg_reg_t;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/rfc_if.sv
// ----------------------------------------------------------------------------
// rfc_if: channel interfaces of the range frame checker
// Byte input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rfc_out_if;
    import rfc_pkg::*;
    logic                valid;
    logic                ready;
    status_t             status;
    logic [RANGE_W-1:0]  range_mm;

    modport source (output valid, output status, output range_mm, input ready);
    modport sink   (input valid, input status, input range_mm, output ready);
endinterface

interface rfc_cfg_if;
    import rfc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RANGE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/range_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// range_frame_checker_unit: byte-serial check of a four-byte range frame
// Counts bytes, runs CRC-8 over the first three, checks header and CRC, and
// classifies the big-endian range against min_mm / max_mm on the last byte.
// ----------------------------------------------------------------------------
//  channel     dir   payload                         beat when
//  byte_in     in    data_byte[7:0], last_byte       valid && ready
//  result_out  out   status[2:0], range_mm[15:0]     valid && ready
//  cfg         in    index[1:0], data[15:0]          valid && ready
//
//  One byte per cycle unless a waiting result stalls it: a beat is held in
//  the input register, then updates the frame state and, on the last byte,
//  loads the result register. Reset clears frame state, valid flags and
//  loads min_mm=500, max_mm=40000. A result waiting in the output register
//  stalls a last byte behind it, and with it the byte input; bytes ahead of
//  it keep flowing. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module range_frame_checker_unit (
    input  logic              clk,
    input  logic              rst_n,
    rfc_in_if.sink            byte_in,
    rfc_out_if.source         result_out,
    rfc_cfg_if.sink           cfg
);
    import rfc_pkg::*;

    // configuration registers
    logic [RANGE_W-1:0] min_mm_reg;
    logic [RANGE_W-1:0] max_mm_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // frame state
    logic [2:0] byte_count_reg, byte_count_next;
    logic [7:0] running_crc_reg, running_crc_next;
    logic       header_good_reg, header_good_next;
    logic [7:0] range_high_reg, range_high_next;
    logic [7:0] range_low_reg, range_low_next;

    // result register
    logic               out_valid_reg;
    status_t            out_status_reg, out_status_next;
    logic [RANGE_W-1:0] out_range_reg, out_range_next;

    logic out_free;
    logic proc_fire;
    logic in_fire;
    logic crc_ok;
    logic [2:0] count_inc;
    logic [RANGE_W-1:0] raw;

    assign out_free  = !out_valid_reg || result_out.ready;
    assign proc_fire = s1_valid_reg && (!s1_last_reg || out_free);
    assign byte_in.ready = !s1_valid_reg || proc_fire;
    assign in_fire   = byte_in.valid && byte_in.ready;
    assign cfg.ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mm_reg <= MIN_MM_RESET;
            max_mm_reg <= MAX_MM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MIN_MM: min_mm_reg <= cfg.data;
                REG_MAX_MM: max_mm_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            s1_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.last_byte;
        end
    end

    // update frame state and build the result
    always_comb
    begin
        header_good_next = header_good_reg;
        range_high_next  = range_high_reg;
        range_low_next   = range_low_reg;
        running_crc_next = running_crc_reg;
        crc_ok           = 1'b0;
        if (byte_count_reg == 3'd0)
        begin
            header_good_next = (s1_byte_reg == HEADER_CHAR);
        end
        if (byte_count_reg == 3'd1)
        begin
            range_high_next = s1_byte_reg;
        end
        if (byte_count_reg == 3'd2)
        begin
            range_low_next = s1_byte_reg;
        end
        if (byte_count_reg == 3'd3)
        begin
            crc_ok = (s1_byte_reg == running_crc_reg);
        end
        if (byte_count_reg < 3'd3)
        begin
            running_crc_next = crc8_update(running_crc_reg, s1_byte_reg);
        end
        count_inc = (byte_count_reg < COUNT_MAX) ? byte_count_reg + 3'd1 : byte_count_reg;
        byte_count_next = count_inc;

        raw = {range_high_next, range_low_next};
        out_range_next = '0;
        if (count_inc != FRAME_LEN)
        begin
            out_status_next = ST_BAD_LENGTH;
        end
        else if (!header_good_next)
        begin
            out_status_next = ST_BAD_HEADER;
        end
        else if (!crc_ok)
        begin
            out_status_next = ST_CRC_MISMATCH;
        end
        else
        begin
            out_range_next = raw;
            if (raw == '0)
            begin
                out_status_next = ST_TOO_CLOSE;
            end
            else if (raw == RAW_ALL_ONES)
            begin
                out_status_next = ST_OUT_OF_RANGE;
            end
            else if (raw == RANGE_W'(1))
            begin
                out_status_next = ST_INVALID;
            end
            else if (raw > max_mm_reg)
            begin
                out_status_next = ST_OUT_OF_RANGE;
            end
            else if (raw < min_mm_reg)
            begin
                out_status_next = ST_TOO_CLOSE;
            end
            else
            begin
                out_status_next = ST_OK;
            end
        end

        // drop frame state after the last byte
        if (s1_last_reg)
        begin
            byte_count_next  = '0;
            running_crc_next = '0;
            header_good_next = 1'b0;
            range_high_next  = '0;
            range_low_next   = '0;
        end
    end

    // advance frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            running_crc_reg <= '0;
            header_good_reg <= 1'b0;
            range_high_reg  <= '0;
            range_low_reg   <= '0;
        end
        else if (proc_fire)
        begin
            byte_count_reg  <= byte_count_next;
            running_crc_reg <= running_crc_next;
            header_good_reg <= header_good_next;
            range_high_reg  <= range_high_next;
            range_low_reg   <= range_low_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= proc_fire && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && s1_last_reg)
        begin
            out_status_reg <= out_status_next;
            out_range_reg  <= out_range_next;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.status   = out_status_reg;
    assign result_out.range_mm = out_range_reg;

`ifndef ASSERT_OFF
    // error results carry no range
    a_err_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && (result_out.status == ST_BAD_LENGTH ||
        result_out.status == ST_BAD_HEADER || result_out.status == ST_CRC_MISMATCH)
        |-> result_out.range_mm == '0)
        else $error("error status with nonzero range");

    // frame state restarts after a last byte
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && s1_last_reg |=> byte_count_reg == '0 && running_crc_reg == '0)
        else $error("frame state not cleared after last byte");

    // a last byte never overwrites a pending result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready |=> out_valid_reg && $stable(out_status_reg))
        else $error("pending result overwritten");
`endif

endmodule

>>> sim/tb_range_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_range_frame_checker_unit: self-checking bench for the range frame checker
// Drives a directed table of frames, then random transfers under eight limit
// settings and four idle mixes. A bit-level CRC-8 frame model predicts every
// report not pinned in the table, and each report beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_range_frame_checker_unit;
    import rfc_pkg::*;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int DRAIN_SLACK      = 4;
    localparam int HOLD_OFF_LEN     = 400;
    localparam int PHASES           = 8;
    localparam int FRAMES_PER_PHASE = 30;
    localparam int SCRIPT_LEN       = 25;
    localparam int MAX_SHOWN        = 10;

    // indexes past the last register: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // how the check byte of a frame is formed
    typedef enum logic [1:0] {
        CRC_AS_IS,
        CRC_GOOD,
        CRC_BAD
    } crc_mode_t;

    typedef struct packed {
        status_t            status;
        logic [RANGE_W-1:0] range_mm;
    } frame_report_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        crc_mode_t     crc;
        logic          pinned;
        frame_report_t report;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rfc_in_if  byte_ch ();
    rfc_out_if report_ch ();
    rfc_cfg_if cfg_ch ();

    range_frame_checker_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (report_ch),
        .cfg        (cfg_ch)
    );

    // directed frames; pinned rows carry a report that reads off at a glance
    script_row_t script [0:SCRIPT_LEN-1] = '{
        '{8'h54, 1'b1, CRC_AS_IS, 1'b1, '{ST_BAD_LENGTH,   16'h0000}},
        '{8'h54, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b1, CRC_GOOD,  1'b1, '{ST_TOO_CLOSE,    16'h0000}},
        '{8'h54, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b1, CRC_GOOD,  1'b1, '{ST_OUT_OF_RANGE, 16'hFFFF}},
        '{8'h54, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h01, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b1, CRC_GOOD,  1'b1, '{ST_INVALID,      16'h0001}},
        '{8'h00, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h12, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h34, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b1, CRC_GOOD,  1'b1, '{ST_BAD_HEADER,   16'h0000}},
        '{8'h54, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h01, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'hF4, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b1, CRC_BAD,   1'b1, '{ST_CRC_MISMATCH, 16'h0000}},
        '{8'h54, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h03, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'hE8, 1'b0, CRC_AS_IS, 1'b0, '{ST_OK,           16'h0000}},
        '{8'h00, 1'b1, CRC_GOOD,  1'b1, '{ST_OK,           16'd1000}}
    };

    // frame model state and its copy of the limits
    logic [2:0]         fr_count;
    logic [7:0]         fr_crc;
    logic               fr_header_ok;
    logic [7:0]         fr_high;
    logic [7:0]         fr_low;
    logic [RANGE_W-1:0] lim_min;
    logic [RANGE_W-1:0] lim_max;

    frame_report_t pending_reports [$];
    frame_report_t head_report;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_reqs  = 0;
    int hold_off_seen  = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int fail_count     = 0;
    int bytes_sent     = 0;
    int transfers_sent = 0;
    int reports_seen   = 0;
    int status_seen [8];

    // clock: period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // CRC-8 poly 0x07, one message bit at a time, MSB first
    function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void frame_clear();
        fr_count     = '0;
        fr_crc       = '0;
        fr_header_ok = 1'b0;
        fr_high      = '0;
        fr_low       = '0;
    endfunction

    // advance the frame model by one byte; give a report on the last byte
    task automatic frame_absorb(input logic [7:0] b, input logic last,
                                output bit has_report, output frame_report_t rep);
        logic               crc_ok;
        logic [RANGE_W-1:0] raw;
        crc_ok     = 1'b0;
        has_report = 1'b0;
        rep        = '0;
        case (fr_count)
            3'd0: fr_header_ok = (b == HEADER_CHAR);
            3'd1: fr_high = b;
            3'd2: fr_low = b;
            3'd3: crc_ok = (b == fr_crc);
            default: ;
        endcase
        if (fr_count < 3'd3)
            fr_crc = crc8_shift(fr_crc, b);
        if (fr_count != COUNT_MAX)
            fr_count = fr_count + 3'd1;
        if (last)
        begin
            if (fr_count != FRAME_LEN)
                rep.status = ST_BAD_LENGTH;
            else if (!fr_header_ok)
                rep.status = ST_BAD_HEADER;
            else if (!crc_ok)
                rep.status = ST_CRC_MISMATCH;
            else
            begin
                raw          = {fr_high, fr_low};
                rep.range_mm = raw;
                // fixed codes first, then the max test, then the min test
                if (raw == '0)
                    rep.status = ST_TOO_CLOSE;
                else if (raw == RAW_ALL_ONES)
                    rep.status = ST_OUT_OF_RANGE;
                else if (raw == 16'd1)
                    rep.status = ST_INVALID;
                else if (raw > lim_max)
                    rep.status = ST_OUT_OF_RANGE;
                else if (raw < lim_min)
                    rep.status = ST_TOO_CLOSE;
                else
                    rep.status = ST_OK;
            end
            has_report = 1'b1;
            frame_clear();
        end
    endtask

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endfunction

    // offer one byte, hold it until its beat, then predict
    task automatic send_byte(input logic [7:0] b, input logic last, input crc_mode_t mode,
                             input logic pinned, input frame_report_t pinned_rep);
        logic [7:0]    value;
        bit            has_report;
        frame_report_t rep;
        value = b;
        if (mode == CRC_GOOD)
            value = fr_crc;
        else if (mode == CRC_BAD)
            value = fr_crc ^ 8'($urandom_range(1, 255));
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        byte_ch.last_byte <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (last)
            transfers_sent++;
        frame_absorb(value, last, has_report, rep);
        if (has_report)
            pending_reports.push_back(pinned ? pinned_rep : rep);
    endtask

    // range values around the fixed codes and the current limits
    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'd1;
            2: return RAW_ALL_ONES;
            3: return lim_min - 16'd1;
            4: return lim_min;
            5: return lim_max;
            6: return lim_max + 16'd1;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // mostly well-formed frames, some broken checks, some noise of one to twelve bytes
    task automatic send_random_frame();
        int                 kind;
        int                 len;
        logic [RANGE_W-1:0] raw;
        logic [7:0]         head;
        kind = $urandom_range(99);
        if (kind < 85)
        begin
            raw  = pick_range();
            head = HEADER_CHAR;
            if (kind >= 78)
            begin
                head = 8'($urandom_range(255));
                if (head == HEADER_CHAR)
                    head = ~head;
            end
            send_byte(head, 1'b0, CRC_AS_IS, 1'b0, '0);
            send_byte(raw[15:8], 1'b0, CRC_AS_IS, 1'b0, '0);
            send_byte(raw[7:0], 1'b0, CRC_AS_IS, 1'b0, '0);
            send_byte(8'h00, 1'b1, (kind >= 70 && kind < 78) ? CRC_BAD : CRC_GOOD, 1'b0, '0);
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)), i == len - 1, CRC_AS_IS, 1'b0, '0);
        end
    endtask

    // drop valid, wait for every report, then let the pipe settle
    task automatic drain_reports();
        byte_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // hold a write until its beat; the caller drops valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_MIN_MM)
            lim_min = value;
        else if (idx == REG_MAX_MM)
            lim_max = value;
    endtask

    task automatic set_limits(input logic [RANGE_W-1:0] min_v, input logic [RANGE_W-1:0] max_v,
                              input bit spare);
        write_reg(REG_MIN_MM, min_v);
        write_reg(REG_MAX_MM, max_v);
        if (spare)
        begin
            write_reg(REG_SPARE_2, 16'($urandom_range(65535)));
            write_reg(REG_SPARE_3, 16'($urandom_range(65535)));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // report sink: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_reqs != hold_off_seen)
        begin
            hold_off_seen = hold_off_reqs;
            hold_left     = HOLD_OFF_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            report_ch.ready <= 1'b0;
        end
        else
            report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each report beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (pending_reports.size() == 0)
                log_failure($sformatf("report with none pending: status %0d range %0d",
                                      report_ch.status, report_ch.range_mm));
            else
            begin
                head_report = pending_reports.pop_front();
                reports_seen++;
                status_seen[head_report.status]++;
                if (report_ch.status !== head_report.status)
                    log_failure($sformatf("report %0d status: expected %0d, got %0d",
                                          reports_seen, head_report.status, report_ch.status));
                if (report_ch.range_mm !== head_report.range_mm)
                    log_failure($sformatf("report %0d range_mm: expected %0d, got %0d",
                                          reports_seen, head_report.range_mm,
                                          report_ch.range_mm));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d reports still pending",
                     cycle_count, pending_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [RANGE_W-1:0] a;
        logic [RANGE_W-1:0] b;
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        lim_min = MIN_MM_RESET;
        lim_max = MAX_MM_RESET;
        frame_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table under the reset limits
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_byte(script[i].data, script[i].last, script[i].crc, script[i].pinned,
                      script[i].report);
        drain_reports();

        // random phases, each with its own limits and idle mix
        for (int p = 0; p < PHASES; p++)
        begin
            a = 16'($urandom_range(65535));
            b = 16'($urandom_range(65535));
            case (p)
                0: set_limits(16'h0000, 16'hFFFF, 1'b0);
                1: set_limits(16'hFFFF, 16'h0000, 1'b0);
                2: set_limits(MIN_MM_RESET, MAX_MM_RESET, 1'b0);
                3: set_limits(16'd1000, 16'd1000, 1'b0);
                4: set_limits(a, b, 1'b1);
                5: set_limits(16'd2, 16'hFFFE, 1'b0);
                6: set_limits((a < b) ? a : b, (a < b) ? b : a, 1'b0);
                default: set_limits(16'h0000, 16'h0000, 1'b0);
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                // block the sink while bytes keep coming, so the input backs up
                if (p == 0 && f == 10)
                    hold_off_reqs++;
                // pause the source until every report is in
                if (p == 5 && f == 15)
                    drain_reports();
                send_random_frame();
            end
            drain_reports();
        end

        $display("Covered %0d bytes in %0d transfers, %0d reports checked, %0d limit settings",
                 bytes_sent, transfers_sent, reports_seen, PHASES + 1);
        $display("Status mix: ok %0d close %0d out %0d invalid %0d length %0d header %0d crc %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_CLOSE], status_seen[ST_OUT_OF_RANGE],
                 status_seen[ST_INVALID], status_seen[ST_BAD_LENGTH], status_seen[ST_BAD_HEADER],
                 status_seen[ST_CRC_MISMATCH]);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> range_frame_checker_unit.f
rtl/rfc_pkg.sv
rtl/rfc_if.sv
rtl/range_frame_checker_unit.sv
sim/tb_range_frame_checker_unit.sv
